@@ rtl/mbv_pkg.sv @@
// Shared types, constants and helper functions for the metaball voxel test core.
package mbv_pkg;

    localparam int BallsDefault = 6;
    localparam int CoordW       = 15;
    localparam int VoxelW       = 7;
    localparam int IndexW       = 3;
    localparam int EnergyW      = 32;
    localparam int DistW        = 32;
    localparam int QuotW        = 32;
    localparam int DivStages    = QuotW;
    localparam int FrontStages  = 3;
    localparam int LaneLatency  = FrontStages + DivStages;
    localparam int CfgIndexW    = 2;
    localparam int InDataW      = 72;
    localparam int OutDataW     = 40;

    localparam logic [EnergyW-1:0] BandReset = 32'd204800;
    localparam logic [EnergyW-1:0] EnergySat = '1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_ENERGY_SCALE = 2'd0,
        REG_BAND_LOW     = 2'd1,
        REG_BAND_HIGH    = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
    } centre_t;

    typedef struct packed {
        logic [VoxelW-1:0] x;
        logic [VoxelW-1:0] y;
        logic [VoxelW-1:0] z;
    } voxel_t;

    function automatic logic [EnergyW-1:0] sat_add(input logic [EnergyW-1:0] a,
                                                   input logic [EnergyW-1:0] b);
        logic [EnergyW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[EnergyW] ? EnergySat : s[EnergyW-1:0];
    endfunction

    function automatic logic [CoordW-1:0] abs_diff(input logic [VoxelW-1:0] v,
                                                   input logic [CoordW-1:0] c);
        logic [CoordW:0] d;
        d = {1'b0, v, 8'b0} - {1'b0, c};
        return d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    endfunction

endpackage

@@ rtl/mbv_lane.sv @@
// One ball lane: distance stages followed by a bit-per-stage quotient pipeline.
module mbv_lane import mbv_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  voxel_t             voxel,
    input  centre_t            centre,
    input  logic [EnergyW-1:0] scale,
    output logic [QuotW-1:0]   term
);

    logic [CoordW-1:0]    ax_reg, ay_reg, az_reg;
    logic [EnergyW-1:0]   s1_scale_reg, s2_scale_reg;
    logic [2*CoordW-1:0]  sx_reg, sy_reg, sz_reg;
    logic [DistW-1:0]     dist_reg [DivStages+1];
    logic [DistW-1:0]     rem_reg  [DivStages+1];
    logic [QuotW-1:0]     nlo_reg  [DivStages+1];
    logic [QuotW-1:0]     q_reg    [DivStages+1];
    logic                 sat_reg  [DivStages+1];
    logic [DistW-1:0]     dist_next;

    assign dist_next = DistW'(sx_reg) + DistW'(sy_reg) + DistW'(sz_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg       <= abs_diff(voxel.x, centre.x);
            ay_reg       <= abs_diff(voxel.y, centre.y);
            az_reg       <= abs_diff(voxel.z, centre.z);
            s1_scale_reg <= scale;
            sx_reg       <= ax_reg * ax_reg;
            sy_reg       <= ay_reg * ay_reg;
            sz_reg       <= az_reg * az_reg;
            s2_scale_reg <= s1_scale_reg;
            dist_reg[0]  <= dist_next;
            rem_reg[0]   <= DistW'(s2_scale_reg[31:16]);
            nlo_reg[0]   <= {s2_scale_reg[15:0], 16'b0};
            q_reg[0]     <= '0;
            sat_reg[0]   <= (dist_next == '0) ||
                            (DistW'(s2_scale_reg[31:16]) >= dist_next);
            for (int k = 0; k < DivStages; k++) begin
                logic [DistW:0] tr;
                tr = {rem_reg[k], nlo_reg[k][QuotW-1]};
                if (tr >= {1'b0, dist_reg[k]}) begin
                    rem_reg[k+1] <= DistW'(tr - {1'b0, dist_reg[k]});
                    q_reg[k+1]   <= {q_reg[k][QuotW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= tr[DistW-1:0];
                    q_reg[k+1]   <= {q_reg[k][QuotW-2:0], 1'b0};
                end
                nlo_reg[k+1]  <= {nlo_reg[k][QuotW-2:0], 1'b0};
                dist_reg[k+1] <= dist_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
            end
        end
    end

    assign term = sat_reg[DivStages] ? EnergySat : q_reg[DivStages];

endmodule

@@ rtl/mbv_accum.sv @@
// Saturating sum of the lane terms, one term added per register stage.
module mbv_accum import mbv_pkg::*; #(
    parameter int BALLS = BallsDefault
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [BALLS-1:0][EnergyW-1:0]   terms,
    output logic [EnergyW-1:0]              energy
);

    logic [BALLS-1:0][EnergyW-1:0] terms_reg [BALLS];
    logic [EnergyW-1:0]            acc_reg   [BALLS];

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg[0] <= terms;
            acc_reg[0]   <= terms[0];
            for (int j = 1; j < BALLS; j++) begin
                terms_reg[j] <= terms_reg[j-1];
                acc_reg[j]   <= sat_add(acc_reg[j-1], terms_reg[j-1][j]);
            end
        end
    end

    assign energy = acc_reg[BALLS-1];

endmodule

@@ rtl/metaball_isosurface_voxel_test_core.sv @@
// Top level of the metaball voxel test core: ball table, configuration and pipeline control.
// The core takes one item per cycle while the result side does not stall. A load transfer
// (tuser 0) writes one ball centre and gives no result; an evaluate transfer (tuser 1) gives
// one result: the front stages form the squared distances, the quotient stages form the
// quotients one bit each, the accumulator stages add the terms, and a last register compares
// against the band. A stall on the result side holds the whole pipeline. Configuration writes
// are always accepted and must be made while the core is idle.
module metaball_isosurface_voxel_test_core import mbv_pkg::*; #(
    parameter int BALLS = BallsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ball_index, ball_x, ball_y, ball_z, voxel_x, voxel_y, voxel_z, zero fill
    input  logic [InDataW-1:0]    s_tdata,
    // command
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // on_border, energy, zero fill
    output logic [OutDataW-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CfgIndexW-1:0]  cfg_index,
    input  logic [EnergyW-1:0]    cfg_data
);

    localparam int Latency = LaneLatency + BALLS + 1;

    logic                          en;
    logic                          in_xfer;
    logic [IndexW-1:0]             ball_index;
    centre_t                       in_centre;
    voxel_t                        in_voxel;
    centre_t                       table_reg [BALLS];
    logic [EnergyW-1:0]            scale_reg, band_low_reg, band_high_reg;
    logic [Latency-1:0]            vld_reg;
    logic [BALLS-1:0][EnergyW-1:0] terms;
    logic [EnergyW-1:0]            sum;
    logic [EnergyW-1:0]            energy_reg;
    logic                          border_reg;

    assign en         = !m_tvalid || m_tready;
    assign s_tready   = en;
    assign in_xfer    = s_tvalid && s_tready;
    assign ball_index = s_tdata[2:0];
    assign in_centre  = '{x: s_tdata[17:3], y: s_tdata[32:18], z: s_tdata[47:33]};
    assign in_voxel   = '{x: s_tdata[54:48], y: s_tdata[61:55], z: s_tdata[68:62]};
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= '0;
            band_low_reg  <= BandReset;
            band_high_reg <= BandReset;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ENERGY_SCALE: scale_reg     <= cfg_data;
                REG_BAND_LOW:     band_low_reg  <= cfg_data;
                REG_BAND_HIGH:    band_high_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BALLS; i++) begin
                table_reg[i] <= '0;
            end
        end else if (in_xfer && cmd_t'(s_tuser) == CMD_LOAD) begin
            for (int i = 0; i < BALLS; i++) begin
                if (32'(ball_index) == i) begin
                    table_reg[i] <= in_centre;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Latency-2:0], s_tvalid && cmd_t'(s_tuser) == CMD_EVAL};
        end
    end

    for (genvar g = 0; g < BALLS; g++) begin : g_lane
        mbv_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .voxel  (in_voxel),
            .centre (table_reg[g]),
            .scale  (scale_reg),
            .term   (terms[g])
        );
    end

    mbv_accum #(.BALLS(BALLS)) u_accum (
        .aclk   (aclk),
        .en     (en),
        .terms  (terms),
        .energy (sum)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            energy_reg <= sum;
            border_reg <= (sum > band_low_reg) && (sum < band_high_reg);
        end
    end

    assign m_tvalid = vld_reg[Latency-1];
    assign m_tdata  = {7'b0, energy_reg, border_reg};

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && cmd_t'(s_tuser) == CMD_LOAD |=> !vld_reg[0])
        else $error("A load entered the result pipeline.");

    a_border_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && border_reg |-> energy_reg != EnergySat)
        else $error("Saturated energy reported on the border.");

    a_border_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && border_reg |-> energy_reg > band_low_reg && energy_reg < band_high_reg)
        else $error("Border flag disagrees with the band.");

endmodule
